### design/arpc_pkg.sv
// Package of types, codes and constants shared by the ARP cache table.
package arpc_pkg;

	localparam int DEF_TABLE_DEPTH = 32;
	localparam logic [15:0] DEF_TIMEOUT = 16'd15;
	localparam int COUNT_W = 6;

	typedef enum logic [2:0] {
		OP_INSERT   = 3'd0,
		OP_LOOKUP   = 3'd1,
		OP_DEL_IP   = 3'd2,
		OP_DEL_MAC  = 3'd3,
		OP_RM_STAT  = 3'd4,
		OP_PURGE_ST = 3'd5,
		OP_PURGE_DY = 3'd6,
		OP_TICK     = 3'd7
	} op_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_HIT     = 3'd1,
		ST_MISS    = 3'd2,
		ST_REFUSED = 3'd3,
		ST_FULL    = 3'd4,
		ST_REFRESH = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_READ,
		FSM_EVAL,
		FSM_FINISH,
		FSM_EMIT
	} fsm_t;

	typedef struct packed {
		logic        is_pinned;
		logic [31:0] ip;
		logic [47:0] mac;
		logic [31:0] stamp;
	} entry_t;

endpackage

### design/arp_cache_table.sv
// Top level of the ARP cache table: entry memory, scan sequencer and result register.
//
//   channel   signals                                         role
//   input     in_valid/in_ready, op, ip_addr, mac_addr, ...   one operation per word
//   output    out_valid/out_ready, status ... last            one or more result words
//   config    cfg_we, cfg_wdata                               timeout_seconds
//
// Every operation scans the table one slot per cycle through the registered read
// port of the entry memory, except while a refresh word waits or the slot after it
// is read again; the memory port sets that pace. Reset clears the valid bits and
// seconds counter at once; no clearing pass is needed. A stalled output holds the
// scan where it is, and a new word is taken only once the final result word has
// gone.
module arp_cache_table #(
	parameter int TABLE_DEPTH = arpc_pkg::DEF_TABLE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  op,
	input  logic [31:0] ip_addr,
	input  logic [47:0] mac_addr,
	input  logic        static_flag,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [47:0] mac_found,
	output logic [31:0] ip_refresh,
	output logic [5:0]  removed_count,
	output logic        changed,
	output logic        last,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);
	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	arpc_pkg::entry_t mem [TABLE_DEPTH];
	arpc_pkg::entry_t rd_q;
	logic [TABLE_DEPTH-1:0] valid_q;
	logic [31:0] seconds_q;
	logic [15:0] timeout_q;

	arpc_pkg::fsm_t state_q, state_d;
	arpc_pkg::op_t op_q;
	logic [31:0] ip_q;
	logic [47:0] mac_q;
	logic        stat_q;
	logic [AW-1:0] rd_addr; // slot being read
	logic [AW-1:0] eval_q;  // slot whose data is in rd_q
	logic        found_q, free_found_q, chg_q;
	logic [AW-1:0] hit_q, free_q;
	logic [CW-1:0] cnt_q;
	logic [47:0] hit_mac_q;
	logic        hit_static_q;
	logic        in_take;

	logic        wr_en;
	logic [AW-1:0] wr_addr;
	arpc_pkg::entry_t wr_data;
	logic        clr_en;
	logic [AW-1:0] clr_addr;

	logic        res_load;
	logic [2:0]  res_status;
	logic [47:0] res_mac;
	logic [31:0] res_ip;
	logic        res_last;

	logic        ev_valid, ev_key, ev_mac_eq, ev_purge;
	logic [31:0] age;
	logic        scan_done;

	assign ev_valid  = valid_q[eval_q];
	assign ev_key    = ev_valid && (rd_q.ip == ip_q);
	assign ev_mac_eq = ev_valid && (rd_q.mac == mac_q);
	assign ev_purge  = ev_valid && (rd_q.is_pinned == (op_q == arpc_pkg::OP_PURGE_ST));
	assign age       = seconds_q - rd_q.stamp;
	assign scan_done = (32'(eval_q) == 32'(TABLE_DEPTH - 1));
	assign in_take   = (state_q == arpc_pkg::FSM_IDLE) && in_valid && !out_valid;

	// After a refresh word the slot that follows is read again before it is evaluated.
	always_comb begin
		case (state_q)
			arpc_pkg::FSM_IDLE: rd_addr = '0;
			arpc_pkg::FSM_EVAL: rd_addr = scan_done ? eval_q : eval_q + AW'(1);
			default: rd_addr = eval_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			timeout_q <= arpc_pkg::DEF_TIMEOUT;
		end else begin
			if (cfg_we) timeout_q <= cfg_wdata;
			if (wr_en) valid_q[wr_addr] <= 1'b1;
			if (clr_en) valid_q[clr_addr] <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= arpc_pkg::FSM_IDLE;
		else         state_q <= state_d;
	end

	// Scan bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seconds_q <= '0;
			eval_q <= '0;
			found_q <= 1'b0;
			free_found_q <= 1'b0;
			chg_q <= 1'b0;
			cnt_q <= '0;
			hit_q <= '0;
			free_q <= '0;
		end else begin
			case (state_q)
				arpc_pkg::FSM_IDLE: begin
					if (in_take) begin
						eval_q <= '0;
						found_q <= 1'b0;
						free_found_q <= 1'b0;
						chg_q <= 1'b0;
						cnt_q <= '0;
						if (op == arpc_pkg::OP_TICK) seconds_q <= seconds_q + 32'd1;
					end
				end
				arpc_pkg::FSM_EMIT: begin
					if (out_ready && !scan_done) eval_q <= eval_q + AW'(1);
				end
				arpc_pkg::FSM_EVAL: begin
					if (!found_q && ((op_q == arpc_pkg::OP_DEL_MAC) ? ev_mac_eq : ev_key)) begin
						found_q <= 1'b1;
						hit_q <= eval_q;
					end
					if (!free_found_q && !ev_valid) begin
						free_found_q <= 1'b1;
						free_q <= eval_q;
					end
					if ((op_q == arpc_pkg::OP_PURGE_ST || op_q == arpc_pkg::OP_PURGE_DY) && ev_purge)
						cnt_q <= cnt_q + CW'(1);
					if (op_q == arpc_pkg::OP_TICK && ev_valid && !rd_q.is_pinned
							&& age > 32'(timeout_q))
						chg_q <= 1'b1;
					if (!scan_done && !res_load) eval_q <= eval_q + AW'(1);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			op_q <= arpc_pkg::op_t'(op);
			ip_q <= ip_addr;
			mac_q <= mac_addr;
			stat_q <= static_flag;
		end
	end

	// Next state, memory writes and results.
	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		wr_en = 1'b0;
		wr_addr = free_q;
		wr_data = '{is_pinned: stat_q, ip: ip_q, mac: mac_q, stamp: seconds_q};
		clr_en = 1'b0;
		clr_addr = eval_q;
		res_load = 1'b0;
		res_status = arpc_pkg::ST_OK;
		res_mac = '0;
		res_ip = '0;
		res_last = 1'b1;
		case (state_q)
			arpc_pkg::FSM_IDLE: begin
				in_ready = !out_valid;
				if (in_valid && !out_valid) state_d = arpc_pkg::FSM_EVAL;
			end
			arpc_pkg::FSM_EVAL: begin
				if ((op_q == arpc_pkg::OP_PURGE_ST || op_q == arpc_pkg::OP_PURGE_DY) && ev_purge)
					clr_en = 1'b1;
				if (op_q == arpc_pkg::OP_TICK && ev_valid && !rd_q.is_pinned) begin
					if (age > 32'(timeout_q)) begin
						clr_en = 1'b1;
					end else if (age == 32'(timeout_q)) begin
						res_load = 1'b1;
						res_status = arpc_pkg::ST_REFRESH;
						res_ip = rd_q.ip;
						res_last = 1'b0;
					end
				end
				if (res_load) state_d = arpc_pkg::FSM_EMIT;
				else if (scan_done) state_d = arpc_pkg::FSM_FINISH;
			end
			arpc_pkg::FSM_EMIT: begin
				// The refresh word waits; the next slot is read once it has been taken.
				if (out_ready) state_d = scan_done ? arpc_pkg::FSM_FINISH : arpc_pkg::FSM_READ;
			end
			arpc_pkg::FSM_READ: state_d = arpc_pkg::FSM_EVAL;
			arpc_pkg::FSM_FINISH: begin
				if (!out_valid || out_ready) begin
					res_load = 1'b1;
					state_d = arpc_pkg::FSM_IDLE;
					clr_addr = hit_q;
					case (op_q)
						arpc_pkg::OP_INSERT: begin
							if (found_q) begin
								wr_addr = hit_q;
								if (stat_q || !hit_static_q) wr_en = 1'b1;
								else res_status = arpc_pkg::ST_REFUSED;
							end else if (free_found_q) wr_en = 1'b1;
							else res_status = arpc_pkg::ST_FULL;
						end
						arpc_pkg::OP_LOOKUP: begin
							if (found_q) begin
								res_status = arpc_pkg::ST_HIT;
								res_mac = hit_mac_q;
							end else res_status = arpc_pkg::ST_MISS;
						end
						arpc_pkg::OP_DEL_IP, arpc_pkg::OP_DEL_MAC: begin
							if (found_q) clr_en = 1'b1;
							else res_status = arpc_pkg::ST_MISS;
						end
						arpc_pkg::OP_RM_STAT: begin
							if (found_q && hit_static_q) clr_en = 1'b1;
							else res_status = arpc_pkg::ST_MISS;
						end
						default: ;
					endcase
				end
			end
			default: state_d = arpc_pkg::FSM_IDLE;
		endcase
	end

	// Data of the slot whose IP matched, captured during the scan.
	always_ff @(posedge clk) begin
		if (state_q == arpc_pkg::FSM_EVAL && !found_q && ev_key) begin
			hit_mac_q <= rd_q.mac;
			hit_static_q <= rd_q.is_pinned;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (res_load) out_valid <= 1'b1;
		else if (out_ready) out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			status <= res_status;
			mac_found <= res_mac;
			ip_refresh <= res_ip;
			removed_count <= ((state_q == arpc_pkg::FSM_FINISH) &&
				(op_q == arpc_pkg::OP_PURGE_ST || op_q == arpc_pkg::OP_PURGE_DY)) ?
				arpc_pkg::COUNT_W'(cnt_q) : '0;
			changed <= (state_q == arpc_pkg::FSM_FINISH) && (op_q == arpc_pkg::OP_TICK) && chg_q;
			last <= res_last;
		end
	end

endmodule

### design/arpc_checker.sv
// Port checker for the ARP cache table, bound to the top level.
module arpc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] status,
	input logic [5:0] removed_count,
	input logic       changed,
	input logic       last
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status))
		else $error("result word dropped while stalled");
	a_refresh_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == arpc_pkg::ST_REFRESH |-> !last)
		else $error("refresh word marked last");
	a_final_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != arpc_pkg::ST_REFRESH |-> last)
		else $error("final word not marked last");
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid)
		else $error("input taken while a result waits");
	a_changed_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && changed |-> last && removed_count == 6'd0)
		else $error("changed flag on an intermediate word");
endmodule

bind arp_cache_table arpc_checker u_arpc_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .status(status),
	.removed_count(removed_count), .changed(changed), .last(last)
);
